@@ hdl/smi_pkg.sv @@
// Shared widths, stage map and saturation helper for the small matrix inverse.
// No dependencies; every other file imports this package.
package smi_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int PROD_W        = 64;  // 32x32 element product
	localparam int COF_W         = 65;  // cofactor, difference of two products
	localparam int NMAG_W        = 64;  // numerator magnitude
	localparam int DPROD_W       = 97;  // cofactor times element
	localparam int DET_W         = 99;  // sum of three such products
	localparam int DMAG_W        = 97;  // determinant magnitude
	localparam int QB            = 32;  // quotient bits resolved per divide
	localparam int NLANE         = 9;

	localparam int FRONT_ST = 5;              // products, cofactors, det
	localparam int PREP_ST  = FRONT_ST;       // operand select and magnitude
	localparam int LANE0_ST = FRONT_ST + 1;   // first divider stage
	localparam int LANE_ST  = QB + 1;         // range check plus one per bit
	localparam int NSTAGE   = LANE0_ST + LANE_ST + 1;
	localparam int OUT_ST   = NSTAGE - 1;

	localparam logic [1:0] SIZE_2 = 2'd2;
	localparam logic [1:0] SIZE_3 = 2'd3;

	// Clamp sign and magnitude to the signed 32-bit range.
	function automatic logic [DATA_W-1:0] sat_mag(input logic neg,
			input logic [DMAG_W-1:0] mag);
		logic [DATA_W-1:0] r;
		if (neg) begin
			if (mag > DMAG_W'(33'h0_8000_0000))
				r = 32'h8000_0000;
			else
				r = ~mag[DATA_W-1:0] + 32'd1;
		end else begin
			if (mag > DMAG_W'(33'h0_7FFF_FFFF))
				r = 32'h7FFF_FFFF;
			else
				r = mag[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ hdl/smi_front.sv @@
// Front end: element products, cofactors and the order-3 determinant.
// Depends on smi_pkg; five register stages driven by per-stage load enables.
module smi_front import smi_pkg::*; (
	input  logic                     clk,
	input  logic [FRONT_ST-1:0]      en,
	input  logic [1:0]               size,
	input  logic signed [DATA_W-1:0] a [NLANE],
	output logic [1:0]               size_o,
	output logic signed [DET_W-1:0]  det_o,
	output logic signed [COF_W-1:0]  cof_o [NLANE],
	output logic signed [DATA_W-1:0] am_o [5]
);

	logic signed [PROD_W-1:0]  p0_s1 [NLANE];
	logic signed [PROD_W-1:0]  p1_s1 [NLANE];
	logic signed [COF_W-1:0]   cof_s2 [NLANE];
	logic signed [COF_W-1:0]   cof_s3 [NLANE];
	logic signed [COF_W-1:0]   cof_s4 [NLANE];
	logic signed [COF_W-1:0]   cof_s5 [NLANE];
	logic signed [COF_W-1:0]   lo_s3 [3];
	logic signed [COF_W-1:0]   hi_s3 [3];
	logic signed [DPROD_W-1:0] dp_s4 [3];
	logic signed [DET_W-1:0]   det_s5;
	// a00, a01, a02, a10, a11 carried along
	logic signed [DATA_W-1:0]  am_s1 [5];
	logic signed [DATA_W-1:0]  am_s2 [5];
	logic signed [DATA_W-1:0]  am_s3 [5];
	logic signed [DATA_W-1:0]  am_s4 [5];
	logic signed [DATA_W-1:0]  am_s5 [5];
	logic [1:0] size_s1, size_s2, size_s3, size_s4, size_s5;

	// Stage 1: the two cyclic products of every cofactor
	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			localparam int I1 = (i + 1) % 3;
			localparam int I2 = (i + 2) % 3;
			localparam int J1 = (j + 1) % 3;
			localparam int J2 = (j + 2) % 3;
			always_ff @(posedge clk) begin
				if (en[0]) begin
					p0_s1[i*3+j] <= a[I1*3+J1] * a[I2*3+J2];
					p1_s1[i*3+j] <= a[I1*3+J2] * a[I2*3+J1];
				end
			end
			// Stage 2: cofactor
			always_ff @(posedge clk) begin
				if (en[1])
					cof_s2[i*3+j] <= COF_W'(p0_s1[i*3+j]) - COF_W'(p1_s1[i*3+j]);
			end
		end
	end

	// Stages 3 and 4: cofactor times top-row element, split into two halves
	for (genvar j = 0; j < 3; j++) begin : g_det
		always_ff @(posedge clk) begin
			if (en[2]) begin
				lo_s3[j] <= am_s2[j] * $signed({1'b0, cof_s2[j][31:0]});
				hi_s3[j] <= am_s2[j] * $signed(cof_s2[j][COF_W-1:32]);
			end
			if (en[3])
				dp_s4[j] <= (DPROD_W'(hi_s3[j]) <<< 32) + DPROD_W'(lo_s3[j]);
		end
	end

	// Stage 5: determinant; elements and order carried through all stages, cofactors from stage 3
	always_ff @(posedge clk) begin
		if (en[0]) begin
			am_s1   <= '{a[0], a[1], a[2], a[3], a[4]};
			size_s1 <= size;
		end
		if (en[1]) begin
			am_s2   <= am_s1;
			size_s2 <= size_s1;
		end
		if (en[2]) begin
			am_s3   <= am_s2;
			cof_s3  <= cof_s2;
			size_s3 <= size_s2;
		end
		if (en[3]) begin
			am_s4   <= am_s3;
			cof_s4  <= cof_s3;
			size_s4 <= size_s3;
		end
		if (en[4]) begin
			am_s5   <= am_s4;
			cof_s5  <= cof_s4;
			size_s5 <= size_s4;
			det_s5  <= DET_W'(dp_s4[0]) + DET_W'(dp_s4[1]) + DET_W'(dp_s4[2]);
		end
	end

	assign size_o = size_s5;
	assign det_o  = det_s5;
	assign cof_o  = cof_s5;
	assign am_o   = am_s5;

endmodule

@@ hdl/smi_prep.sv @@
// Operand select: divisor, per-lane numerators, signs and the determinant output.
// Depends on smi_pkg; one register stage.
module smi_prep import smi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [1:0]               size,
	input  logic signed [DET_W-1:0]  det3,
	input  logic signed [COF_W-1:0]  cof [NLANE],
	input  logic signed [DATA_W-1:0] am [5],
	output logic [NMAG_W-1:0]        nmag [NLANE],
	output logic [DMAG_W-1:0]        dmag,
	output logic [NLANE-1:0]         neg,
	output logic [NLANE-1:0]         zero,
	output logic [DATA_W-1:0]        det_out,
	output logic                     sing
);

	logic                     sz3, sz2, dneg, dzero;
	logic signed [DET_W-1:0]  dsel;
	logic [DET_W-1:0]         dabs;
	logic [DATA_W-1:0]        dout;
	logic [NMAG_W-1:0]        nmag_s6 [NLANE];
	logic [DMAG_W-1:0]        dmag_s6;
	logic [NLANE-1:0]         neg_s6, zero_s6;
	logic [DATA_W-1:0]        dout_s6;
	logic                     sing_s6;

	assign sz3 = (size == SIZE_3);
	assign sz2 = (size == SIZE_2);

	// Divisor: order-3 det, order-2 det (cofactor 2,2), or a00
	always_comb begin
		if (sz3)
			dsel = det3;
		else if (sz2)
			dsel = DET_W'(cof[8]);
		else
			dsel = DET_W'(am[0]);
		dneg  = dsel[DET_W-1];
		dabs  = dneg ? -dsel : dsel;
		dzero = (dsel == '0);
		if (dzero)
			dout = '0;
		else if (sz3)
			dout = sat_mag(dneg, DMAG_W'(dabs >> (2 * FRAC_BITS)));
		else if (sz2)
			dout = sat_mag(dneg, DMAG_W'(dabs >> FRAC_BITS));
		else
			dout = am[0];
	end

	// Per output position: numerator and whether the position is in use
	for (genvar l = 0; l < NLANE; l++) begin : g_lane
		localparam int R = l / 3;
		localparam int C = l % 3;
		localparam bit IN2 = (R < 2) && (C < 2);
		localparam logic signed [COF_W-1:0] N1 = (l == 0) ? COF_W'(1) : COF_W'(0);
		logic signed [COF_W-1:0] n2, nv;
		logic [COF_W-1:0]        na;
		logic                    act;

		if (l == 0) begin : g_n0
			assign n2 = COF_W'(am[4]);
		end else if (l == 1) begin : g_n1
			assign n2 = -COF_W'(am[1]);
		end else if (l == 3) begin : g_n3
			assign n2 = -COF_W'(am[3]);
		end else if (l == 4) begin : g_n4
			assign n2 = COF_W'(am[0]);
		end else begin : g_nz
			assign n2 = '0;
		end

		always_comb begin
			if (sz3)
				nv = cof[C*3+R];
			else if (sz2)
				nv = n2;
			else
				nv = N1;
			na  = nv[COF_W-1] ? -nv : nv;
			act = sz3 || (sz2 && IN2) || (l == 0);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nmag_s6[l] <= na[NMAG_W-1:0];
				neg_s6[l]  <= nv[COF_W-1] ^ dneg;
				zero_s6[l] <= !act || dzero;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s6 <= dabs[DMAG_W-1:0];
			dout_s6 <= dout;
			sing_s6 <= dzero;
		end
	end

	assign nmag    = nmag_s6;
	assign dmag    = dmag_s6;
	assign neg     = neg_s6;
	assign zero    = zero_s6;
	assign det_out = dout_s6;
	assign sing    = sing_s6;

endmodule

@@ hdl/smi_div_lane.sv @@
// One pipelined restoring divider lane: trunc(n * 2^(2F) / d), one quotient bit per stage.
// Depends on smi_pkg; a range-check stage followed by QB bit stages.
module smi_div_lane import smi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic [LANE_ST-1:0]  en,
	input  logic [NMAG_W-1:0]   nmag,
	input  logic [DMAG_W-1:0]   dmag,
	input  logic                neg,
	input  logic                zero,
	output logic [QB-1:0]       quo,
	output logic                ovf,
	output logic                neg_o,
	output logic                zero_o
);

	localparam int NW = NMAG_W + 2 * FRAC_BITS;

	logic [NW-1:0]     nsh;
	logic [DMAG_W-1:0] nhi;
	logic [DMAG_W-1:0] rem_s [QB];
	logic [QB-1:0]     low_s [QB];
	logic [DMAG_W-1:0] dv_s  [QB];
	logic [QB-1:0]     quo_s [QB+1];
	logic [QB:0]       ovf_s, neg_s, zero_s;

	assign nsh = {nmag, {(2 * FRAC_BITS){1'b0}}};
	assign nhi = DMAG_W'(nsh[NW-1:QB]);

	// Range check: quotient of 2^QB or more saturates
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0]  <= nhi;
			low_s[0]  <= nsh[QB-1:0];
			dv_s[0]   <= dmag;
			quo_s[0]  <= '0;
			ovf_s[0]  <= (nhi >= dmag);
			neg_s[0]  <= neg;
			zero_s[0] <= zero;
		end
	end

	// One restoring step per stage
	for (genvar k = 1; k <= QB; k++) begin : g_bit
		logic [DMAG_W:0] r2, diff;
		logic            ge;
		assign r2   = {rem_s[k-1], low_s[k-1][QB-1]};
		assign diff = r2 - {1'b0, dv_s[k-1]};
		assign ge   = (r2 >= {1'b0, dv_s[k-1]});

		always_ff @(posedge clk) begin
			if (en[k]) begin
				quo_s[k]  <= {quo_s[k-1][QB-2:0], ge};
				ovf_s[k]  <= ovf_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				zero_s[k] <= zero_s[k-1];
			end
		end

		if (k < QB) begin : g_rem
			always_ff @(posedge clk) begin
				if (en[k]) begin
					rem_s[k] <= ge ? diff[DMAG_W-1:0] : r2[DMAG_W-1:0];
					low_s[k] <= {low_s[k-1][QB-2:0], 1'b0};
					dv_s[k]  <= dv_s[k-1];
				end
			end
		end
	end

	assign quo    = quo_s[QB];
	assign ovf    = ovf_s[QB];
	assign neg_o  = neg_s[QB];
	assign zero_o = zero_s[QB];

endmodule

@@ hdl/small_matrix_inverse_det.sv @@
// Small matrix inverse and determinant (order 1 to 3, signed fixed point).
// Pipeline: 5 product/det stages, 1 operand stage, 33 divider stages,
// 1 output register. Throughput: one matrix per cycle unless out_ready stalls;
// nine divider lanes each resolve one bit per stage.
// Reset clears the stage valid bits only; data registers are not reset.
module small_matrix_inverse_det import smi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               size,
	input  logic signed [DATA_W-1:0] a00,
	input  logic signed [DATA_W-1:0] a01,
	input  logic signed [DATA_W-1:0] a02,
	input  logic signed [DATA_W-1:0] a10,
	input  logic signed [DATA_W-1:0] a11,
	input  logic signed [DATA_W-1:0] a12,
	input  logic signed [DATA_W-1:0] a20,
	input  logic signed [DATA_W-1:0] a21,
	input  logic signed [DATA_W-1:0] a22,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] i00,
	output logic signed [DATA_W-1:0] i01,
	output logic signed [DATA_W-1:0] i02,
	output logic signed [DATA_W-1:0] i10,
	output logic signed [DATA_W-1:0] i11,
	output logic signed [DATA_W-1:0] i12,
	output logic signed [DATA_W-1:0] i20,
	output logic signed [DATA_W-1:0] i21,
	output logic signed [DATA_W-1:0] i22,
	output logic signed [DATA_W-1:0] determinant,
	output logic                     singular
);

	logic [NSTAGE-1:0]        vld_s;
	logic [NSTAGE-1:0]        rdy;
	logic signed [DATA_W-1:0] a_in [NLANE];
	logic [1:0]               f_size;
	logic signed [DET_W-1:0]  f_det;
	logic signed [COF_W-1:0]  f_cof [NLANE];
	logic signed [DATA_W-1:0] f_am [5];
	logic [NMAG_W-1:0]        p_nmag [NLANE];
	logic [DMAG_W-1:0]        p_dmag;
	logic [NLANE-1:0]         p_neg, p_zero;
	logic [DATA_W-1:0]        p_det;
	logic                     p_sing;
	logic [QB-1:0]            l_quo [NLANE];
	logic [NLANE-1:0]         l_ovf, l_neg, l_zero;
	logic [DATA_W-1:0]        detp_s [LANE_ST];
	logic [LANE_ST-1:0]       sgp_s;
	logic [DATA_W-1:0]        res_s40 [NLANE];
	logic [DATA_W-1:0]        det_s40;
	logic                     sing_s40;

	assign a_in = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

	// Stage load enables: a stage advances when empty or its successor advances
	for (genvar k = 0; k < NSTAGE; k++) begin : g_rdy
		if (k == NSTAGE - 1) begin : g_last
			assign rdy[k] = !vld_s[k] || out_ready;
		end else begin : g_mid
			assign rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NSTAGE; k++) begin
				if (rdy[k])
					vld_s[k] <= (k == 0) ? in_valid : vld_s[k-1];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[OUT_ST];

	smi_front u_front (
		.clk    (clk),
		.en     (rdy[FRONT_ST-1:0]),
		.size   (size),
		.a      (a_in),
		.size_o (f_size),
		.det_o  (f_det),
		.cof_o  (f_cof),
		.am_o   (f_am)
	);

	smi_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
		.clk     (clk),
		.en      (rdy[PREP_ST]),
		.size    (f_size),
		.det3    (f_det),
		.cof     (f_cof),
		.am      (f_am),
		.nmag    (p_nmag),
		.dmag    (p_dmag),
		.neg     (p_neg),
		.zero    (p_zero),
		.det_out (p_det),
		.sing    (p_sing)
	);

	for (genvar l = 0; l < NLANE; l++) begin : g_div
		smi_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk    (clk),
			.en     (rdy[LANE0_ST +: LANE_ST]),
			.nmag   (p_nmag[l]),
			.dmag   (p_dmag),
			.neg    (p_neg[l]),
			.zero   (p_zero[l]),
			.quo    (l_quo[l]),
			.ovf    (l_ovf[l]),
			.neg_o  (l_neg[l]),
			.zero_o (l_zero[l])
		);
	end

	// Carry determinant and singular flag alongside the divider lanes
	always_ff @(posedge clk) begin
		for (int k = 0; k < LANE_ST; k++) begin
			if (rdy[LANE0_ST + k]) begin
				detp_s[k] <= (k == 0) ? p_det : detp_s[k-1];
				sgp_s[k]  <= (k == 0) ? p_sing : sgp_s[k-1];
			end
		end
	end

	// Output register: saturate quotients, zero unused or singular positions
	always_ff @(posedge clk) begin
		if (rdy[OUT_ST]) begin
			for (int l = 0; l < NLANE; l++) begin
				res_s40[l] <= l_zero[l] ? '0
					: sat_mag(l_neg[l], DMAG_W'({l_ovf[l], l_quo[l]}));
			end
			det_s40  <= detp_s[LANE_ST-1];
			sing_s40 <= sgp_s[LANE_ST-1];
		end
	end

	assign i00         = res_s40[0];
	assign i01         = res_s40[1];
	assign i02         = res_s40[2];
	assign i10         = res_s40[3];
	assign i11         = res_s40[4];
	assign i12         = res_s40[5];
	assign i20         = res_s40[6];
	assign i21         = res_s40[7];
	assign i22         = res_s40[8];
	assign determinant = det_s40;
	assign singular    = sing_s40;

	// A singular result carries a zero determinant and a zero inverse (diagonal checked)
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> determinant == '0 && i00 == '0 && i11 == '0 && i22 == '0)
		else $error("singular result with nonzero fields");

	// An input transfer always lands in the first stage
	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s[0])
		else $error("accepted matrix lost at entry");

	// A full last divider stage moves into a free output register
	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[OUT_ST-1] && rdy[OUT_ST] |=> out_valid)
		else $error("result dropped before output register");

endmodule

@@ bench/small_matrix_inverse_det_tb.sv @@
// Self-checking bench for small_matrix_inverse_det: matrices of size code 0..3 are driven
// through valid/ready, predicted here in wide integers and checked field by field.
// Depends on smi_pkg and the small_matrix_inverse_det RTL.
module small_matrix_inverse_det_tb import smi_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC    = 16;
	localparam int N_RAND  = 1400;
	localparam int WD_LIMIT = 5000;

	typedef logic signed [127:0] wide_t;
	typedef logic signed [DATA_W-1:0] elem_t;

	typedef struct {
		logic [1:0] size;
		elem_t      a [9];
	} matrix_t;

	typedef struct {
		elem_t inv [9];
		elem_t det;
		logic  sing;
	} inverse_t;

	// Scoreboard: predicts inverse/determinant per accepted matrix, checks results in order
	class inverse_scoreboard;
		inverse_t pending [$];
		int       errors = 0;

		static function elem_t clamp(logic neg, logic [127:0] mag);
			if (neg)
				return (mag > 128'h8000_0000) ? elem_t'(32'h8000_0000) : elem_t'(-mag[31:0]);
			return (mag > 128'h7FFF_FFFF) ? elem_t'(32'h7FFF_FFFF) : elem_t'(mag[31:0]);
		endfunction

		static function logic [127:0] mag_of(wide_t v);
			return v[127] ? -v : v;
		endfunction

		// truncate num * 2^(2F) / den toward zero, then clamp
		static function elem_t quotient(wide_t num, wide_t den);
			return clamp(num[127] ^ den[127], (mag_of(num) << (2 * FRAC)) / mag_of(den));
		endfunction

		static function elem_t shrink(wide_t v, int n);
			return clamp(v[127], mag_of(v) >> n);
		endfunction

		function void note(matrix_t m);
			inverse_t r;
			wide_t    e [3][3];
			wide_t    cof [3][3];
			wide_t    det;
			foreach (r.inv[k]) r.inv[k] = '0;
			r.det = '0;
			r.sing = 1'b0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					e[i][j] = wide_t'(m.a[i * 3 + j]);
			if (m.size == SIZE_3) begin
				det = '0;
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						cof[i][j] = e[(i+1)%3][(j+1)%3] * e[(i+2)%3][(j+2)%3]
							- e[(i+1)%3][(j+2)%3] * e[(i+2)%3][(j+1)%3];
				for (int j = 0; j < 3; j++) det += cof[0][j] * e[0][j];
				if (det == 0)
					r.sing = 1'b1;
				else begin
					r.det = shrink(det, 2 * FRAC);
					// adjugate is the transposed cofactor matrix
					for (int i = 0; i < 3; i++)
						for (int j = 0; j < 3; j++)
							r.inv[j * 3 + i] = quotient(cof[i][j], det);
				end
			end else if (m.size == SIZE_2) begin
				det = e[0][0] * e[1][1] - e[0][1] * e[1][0];
				if (det == 0)
					r.sing = 1'b1;
				else begin
					r.det = shrink(det, FRAC);
					r.inv[0] = quotient(e[1][1], det);
					r.inv[1] = quotient(-e[0][1], det);
					r.inv[3] = quotient(-e[1][0], det);
					r.inv[4] = quotient(e[0][0], det);
				end
			end else begin
				// order 1, and size zero behaves the same
				if (e[0][0] == 0)
					r.sing = 1'b1;
				else begin
					r.det = m.a[0];
					r.inv[0] = quotient(wide_t'(1), e[0][0]);
				end
			end
			pending.push_back(r);
		endfunction

		function void check(inverse_t got);
			inverse_t exp_r;
			if (pending.size() == 0) begin
				$error("result transfer with no matrix outstanding");
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			foreach (got.inv[k])
				if (got.inv[k] !== exp_r.inv[k]) begin
					$error("i%0d%0d: expected %h, got %h", k / 3, k % 3, exp_r.inv[k], got.inv[k]);
					errors++;
				end
			if (got.det !== exp_r.det) begin
				$error("determinant: expected %h, got %h", exp_r.det, got.det);
				errors++;
			end
			if (got.sing !== exp_r.sing) begin
				$error("singular: expected %b, got %b", exp_r.sing, got.sing);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] size = '0;
	elem_t      a00 = '0, a01 = '0, a02 = '0, a10 = '0, a11 = '0, a12 = '0;
	elem_t      a20 = '0, a21 = '0, a22 = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	elem_t      i00, i01, i02, i10, i11, i12, i20, i21, i22, determinant;
	logic       singular;

	inverse_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	small_matrix_inverse_det dut (.*);

	// Stall the result side at the current rate
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Check each result transfer; trip the watchdog when nothing moves
	always @(posedge clk) begin
		inverse_t got;
		if (out_valid && out_ready) begin
			got.inv = '{i00, i01, i02, i10, i11, i12, i20, i21, i22};
			got.det = determinant;
			got.sing = singular;
			sb.check(got);
		end
		if ((out_valid && out_ready) || (in_valid && in_ready))
			quiet_cycles <= 0;
		else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WD_LIMIT) begin
				$display("small_matrix_inverse_det_tb: errors");
				$finish;
			end
		end
	end

	task automatic send(matrix_t m);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		size <= m.size;
		{a00, a01, a02, a10, a11, a12, a20, a21, a22} <=
			{m.a[0], m.a[1], m.a[2], m.a[3], m.a[4], m.a[5], m.a[6], m.a[7], m.a[8]};
		do @(posedge clk); while (!in_ready);
		sb.note(m);
	endtask

	function automatic elem_t pick_elem();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return elem_t'($urandom_range(32'h8_0000)) - elem_t'(32'h4_0000);
			5, 6:          return elem_t'($urandom);
			7: begin
				case ($urandom_range(5))
					0: return elem_t'(32'h8000_0000);
					1: return elem_t'(32'h7FFF_FFFF);
					2: return '0;
					3: return elem_t'(1);
					4: return elem_t'(-1);
					default: return elem_t'(32'h1_0000);
				endcase
			end
			8:       return elem_t'($urandom_range(511)) - elem_t'(256);
			default: return elem_t'($urandom_range(32'hFFF_FFFF)) - elem_t'(32'h800_0000);
		endcase
	endfunction

	function automatic matrix_t random_matrix();
		matrix_t m;
		m.size = 2'($urandom_range(3));
		foreach (m.a[k]) m.a[k] = pick_elem();
		// make some of them singular by repeating a row (order 1: zero a00)
		if ($urandom_range(9) == 0) begin
			if (m.size == SIZE_3)
				for (int j = 0; j < 3; j++) m.a[6 + j] = m.a[j];
			else if (m.size == SIZE_2)
				for (int j = 0; j < 2; j++) m.a[3 + j] = m.a[j];
			else
				m.a[0] = '0;
		end
		return m;
	endfunction

	function automatic matrix_t make(logic [1:0] sz, elem_t v [9]);
		matrix_t m;
		m.size = sz;
		m.a = v;
		return m;
	endfunction

	localparam elem_t ONE = 32'h1_0000;
	localparam elem_t MAXV = 32'h7FFF_FFFF;
	localparam elem_t MINV = 32'h8000_0000;

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identities, singular and extreme matrices of every order
		send(make(SIZE_3, '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}));
		send(make(SIZE_2, '{ONE, 0, 0, 0, ONE, 0, 0, 0, 0}));
		send(make(2'd1, '{ONE, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}));
		send(make(2'd0, '{2 * ONE, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV}));
		send(make(2'd1, '{0, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE}));
		send(make(2'd0, '{0, 0, 0, 0, 0, 0, 0, 0, 0}));
		send(make(2'd1, '{1, 0, 0, 0, 0, 0, 0, 0, 0}));
		send(make(2'd1, '{-1, 0, 0, 0, 0, 0, 0, 0, 0}));
		send(make(2'd1, '{MAXV, 0, 0, 0, 0, 0, 0, 0, 0}));
		send(make(2'd1, '{MINV, 0, 0, 0, 0, 0, 0, 0, 0}));
		send(make(SIZE_2, '{0, 0, 0, 0, 0, 0, 0, 0, 0}));
		send(make(SIZE_2, '{ONE, 2 * ONE, 2 * ONE, 4 * ONE, 0, 0, 0, 0, 0}));
		send(make(SIZE_2, '{MAXV, MINV, MINV, MAXV, 0, 0, 0, 0, 0}));
		send(make(SIZE_2, '{MINV, MINV, MINV, MAXV, 0, 0, 0, 0, 0}));
		send(make(SIZE_2, '{1, 0, 0, 1, 0, 0, 0, 0, 0}));
		send(make(SIZE_3, '{0, 0, 0, 0, 0, 0, 0, 0, 0}));
		send(make(SIZE_3, '{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
			7 * ONE, 8 * ONE, 9 * ONE}));
		send(make(SIZE_3, '{2 * ONE, ONE, 0, ONE, 3 * ONE, ONE, 0, ONE, 4 * ONE}));
		send(make(SIZE_3, '{MAXV, MINV, MAXV, MINV, MAXV, MAXV, MAXV, MAXV, MINV}));
		send(make(SIZE_3, '{MINV, 0, 0, 0, MINV, 0, 0, 0, MINV}));
		send(make(SIZE_3, '{1, 0, 0, 0, 1, 0, 0, 0, 1}));
		send(make(SIZE_3, '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0}));

		// random matrices under four idling patterns
		for (int n = 0; n < N_RAND; n++) begin
			case (n / (N_RAND / 4))
				0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			send(random_matrix());
		end
		in_valid <= 1'b0;

		// drain, then allow for the pipeline depth
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0)
			$display("small_matrix_inverse_det_tb: clean");
		else
			$display("small_matrix_inverse_det_tb: errors");
		$finish;
	end
endmodule
